// ===== sv/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg: shared types and constants of the script lexer tokenizer
// token codes, scan modes, result word layout and character helpers
// ----------------------------------------------------------------------------
package slt_pkg;

	localparam logic [5:0] K_END      = 6'd0;
	localparam logic [5:0] K_IDENT    = 6'd1;
	localparam logic [5:0] K_NUMBER   = 6'd2;
	localparam logic [5:0] K_STRING   = 6'd3;
	localparam logic [5:0] K_DOT      = 6'd11;
	localparam logic [5:0] K_KEYWORD0 = 6'd28;
	localparam logic [5:0] K_ERROR    = 6'd44;

	localparam logic [1:0] E_NONE   = 2'd0;
	localparam logic [1:0] E_CHAR   = 2'd1;
	localparam logic [1:0] E_STRING = 2'd2;
	localparam logic [1:0] E_LONE   = 2'd3;

	localparam logic [15:0] LEN_MAX  = 16'hFFFF;
	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

	typedef enum logic [6:0] {
		M_IDLE   = 7'b0000001,
		M_IDENT  = 7'b0000010,
		M_INT    = 7'b0000100,
		M_DOT    = 7'b0001000,
		M_FRAC   = 7'b0010000,
		M_STRING = 7'b0100000,
		M_OP     = 7'b1000000
	} mode_t;

	typedef struct packed {
		logic [5:0]  kind;
		logic [31:0] start;
		logic [15:0] len;
		logic [23:0] line;
		logic [1:0]  err;
		logic        last;
	} tok_t;

	function automatic logic is_letter(input logic [7:0] b);
		return b == 8'h5F || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_numeral(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_space(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
	endfunction

	function automatic logic [5:0] single_op(input logic [7:0] b);
		logic [5:0] r;
		unique case (b)
			8'h28: r = 6'd4;
			8'h29: r = 6'd5;
			8'h7B: r = 6'd6;
			8'h7D: r = 6'd7;
			8'h5B: r = 6'd8;
			8'h5D: r = 6'd9;
			8'h2C: r = 6'd10;
			8'h2E: r = 6'd11;
			8'h3B: r = 6'd12;
			8'h2D: r = 6'd13;
			8'h2B: r = 6'd14;
			8'h2F: r = 6'd15;
			8'h2A: r = 6'd16;
			8'h25: r = 6'd17;
			default: r = 6'd0;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] pair_code(input logic [7:0] f, input logic pair);
		logic [5:0] r;
		unique case (f)
			8'h3D: r = pair ? 6'd22 : 6'd18;
			8'h21: r = pair ? 6'd23 : 6'd19;
			8'h3C: r = pair ? 6'd24 : 6'd20;
			8'h3E: r = pair ? 6'd25 : 6'd21;
			8'h7C: r = 6'd26;
			default: r = 6'd27;
		endcase
		return r;
	endfunction

	// keyword text packed first character in the low byte
	localparam int KW_N = 16;
	typedef logic [63:0] kw_text_t [KW_N];
	typedef logic [3:0]  kw_len_t  [KW_N];
	localparam kw_text_t KW_TEXT = '{
		64'h65757274, 64'h65736C6166, 64'h6C6C756E, 64'h6669,
		64'h65736C65, 64'h726176, 64'h726F66, 64'h656C696877,
		64'h6E7275746572, 64'h6E6F6974636E7566, 64'h7373616C63, 64'h7265707573,
		64'h73696874, 64'h77656E, 64'h6D6172676F7270, 64'h746E697270
	};
	localparam kw_len_t KW_LEN = '{
		4'd4, 4'd5, 4'd4, 4'd2, 4'd4, 4'd3, 4'd3, 4'd5,
		4'd6, 4'd8, 4'd5, 4'd5, 4'd4, 4'd3, 4'd7, 4'd5
	};

endpackage

// ===== sv/slt_front.sv =====
// ----------------------------------------------------------------------------
// slt_front: scanner
// takes one byte or end mark per cycle while the queue has room and produces up to three tokens
// ----------------------------------------------------------------------------
module slt_front #(
	parameter int KEYWORD_MAX = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_end,
	input  logic [7:0]       in_byte,
	output logic             in_ready,
	output logic [1:0]       push_n,
	output slt_pkg::tok_t    push_tok [3],
	input  logic             room
);
	import slt_pkg::*;

	localparam int WB = $clog2(KEYWORD_MAX);

	mode_t       mode_q;
	logic [31:0] begin_q, pos_q;
	logic [15:0] len_q;
	logic [23:0] line_q;
	logic [7:0]  pend_q;
	logic        err_q;
	logic [7:0]  wbuf_q [KEYWORD_MAX];

	assign in_ready = room;
	wire take = in_valid && room;

	// keyword match on the current word
	logic [5:0] word_kind;
	always_comb begin
		logic [63:0] w;
		w = '0;
		for (int i = 0; i < 8; i++)
			if (i < KEYWORD_MAX && 16'(i) < len_q) w[i*8 +: 8] = wbuf_q[i];
		word_kind = K_IDENT;
		for (int k = KW_N - 1; k >= 0; k--)
			if (len_q == 16'(KW_LEN[k]) && w == KW_TEXT[k])
				word_kind = K_KEYWORD0 + 6'(k);
	end

	mode_t       n_mode;
	logic [31:0] n_begin;
	logic [15:0] n_len;
	logic [7:0]  n_pend;
	logic        n_err, wb_we;
	logic [WB-1:0] wb_a;
	logic [1:0]  n;
	tok_t        t [3];

	always_comb begin
		logic restart, latched;
		logic [5:0] op;
		logic [15:0] l1;
		l1 = (len_q < LEN_MAX) ? len_q + 16'd1 : len_q;
		n_mode = mode_q; n_begin = begin_q; n_len = len_q; n_pend = pend_q;
		n_err = err_q; wb_we = 1'b0; wb_a = '0; n = '0; restart = 1'b0;
		latched = err_q;
		for (int i = 0; i < 3; i++) t[i] = '{kind: K_END, start: pos_q, len: '0,
			line: line_q, err: E_NONE, last: 1'b0};
		op = single_op(in_byte);
		if (in_end) begin
			if (!err_q) begin
				unique case (mode_q)
					M_IDENT: begin
						t[0] = '{word_kind, begin_q, len_q, line_q, E_NONE, 1'b0}; n = 2'd1;
					end
					M_INT, M_FRAC: begin
						t[0] = '{K_NUMBER, begin_q, len_q, line_q, E_NONE, 1'b0}; n = 2'd1;
					end
					M_DOT: begin
						t[0] = '{K_NUMBER, begin_q, len_q, line_q, E_NONE, 1'b0};
						t[1] = '{K_DOT, pos_q - 32'd1, 16'd1, line_q, E_NONE, 1'b0}; n = 2'd2;
					end
					M_STRING: begin
						t[0] = '{K_ERROR, begin_q, len_q, line_q, E_STRING, 1'b0}; n = 2'd1;
					end
					M_OP: begin
						if (pend_q == 8'h7C || pend_q == 8'h26)
							t[0] = '{K_ERROR, pos_q - 32'd1, 16'd1, line_q, E_LONE, 1'b0};
						else
							t[0] = '{pair_code(pend_q, 1'b0), pos_q - 32'd1, 16'd1, line_q,
								E_NONE, 1'b0};
						n = 2'd1;
					end
					default: ;
				endcase
			end
			t[n] = '{K_END, pos_q, 16'd0, line_q, E_NONE, 1'b0};
			n = n + 2'd1;
			n_mode = M_IDLE; n_begin = '0; n_len = '0; n_pend = '0; n_err = 1'b0;
		end else if (!err_q) begin
			unique case (mode_q)
				M_IDENT: begin
					if (is_letter(in_byte) || is_numeral(in_byte)) begin
						wb_we = len_q < 16'(KEYWORD_MAX); wb_a = len_q[WB-1:0]; n_len = l1;
					end else begin
						t[0] = '{word_kind, begin_q, len_q, line_q, E_NONE, 1'b0}; n = 2'd1;
						restart = 1'b1;
					end
				end
				M_INT: begin
					if (is_numeral(in_byte)) n_len = l1;
					else if (in_byte == 8'h2E) n_mode = M_DOT;
					else begin
						t[0] = '{K_NUMBER, begin_q, len_q, line_q, E_NONE, 1'b0}; n = 2'd1;
						restart = 1'b1;
					end
				end
				M_DOT: begin
					if (is_numeral(in_byte)) begin
						n_len = (l1 < LEN_MAX) ? l1 + 16'd1 : l1; n_mode = M_FRAC;
					end else begin
						t[0] = '{K_NUMBER, begin_q, len_q, line_q, E_NONE, 1'b0};
						t[1] = '{K_DOT, pos_q - 32'd1, 16'd1, line_q, E_NONE, 1'b0};
						n = 2'd2; restart = 1'b1;
					end
				end
				M_FRAC: begin
					if (is_numeral(in_byte)) n_len = l1;
					else begin
						t[0] = '{K_NUMBER, begin_q, len_q, line_q, E_NONE, 1'b0}; n = 2'd1;
						restart = 1'b1;
					end
				end
				M_STRING: begin
					if (in_byte == 8'h22) begin
						t[0] = '{K_STRING, begin_q, len_q, line_q, E_NONE, 1'b0}; n = 2'd1;
						n_mode = M_IDLE;
					end else n_len = l1;
				end
				M_OP: begin
					if (pend_q == 8'h7C || pend_q == 8'h26) begin
						if (in_byte == pend_q) begin
							t[0] = '{pair_code(pend_q, 1'b1), pos_q - 32'd1, 16'd2, line_q,
								E_NONE, 1'b0};
							n_mode = M_IDLE;
						end else begin
							t[0] = '{K_ERROR, pos_q - 32'd1, 16'd1, line_q, E_LONE, 1'b0};
							n_err = 1'b1; n_mode = M_IDLE;
						end
						n = 2'd1;
					end else if (in_byte == 8'h3D) begin
						t[0] = '{pair_code(pend_q, 1'b1), pos_q - 32'd1, 16'd2, line_q,
							E_NONE, 1'b0};
						n = 2'd1; n_mode = M_IDLE;
					end else begin
						t[0] = '{pair_code(pend_q, 1'b0), pos_q - 32'd1, 16'd1, line_q,
							E_NONE, 1'b0};
						n = 2'd1; restart = 1'b1;
					end
				end
				default: restart = 1'b1;
			endcase
			// start of a fresh token on this byte
			if (restart) begin
				n_mode = M_IDLE; n_begin = pos_q; n_len = '0;
				if (is_space(in_byte)) ;
				else if (is_letter(in_byte)) begin
					n_mode = M_IDENT; n_len = 16'd1; wb_we = 1'b1; wb_a = '0;
				end else if (is_numeral(in_byte)) begin
					n_mode = M_INT; n_len = 16'd1;
				end else if (in_byte == 8'h22) begin
					n_mode = M_STRING; n_begin = pos_q + 32'd1;
				end else if (op != 6'd0) begin
					t[n] = '{op, pos_q, 16'd1, line_q, E_NONE, 1'b0}; n = n + 2'd1;
				end else if (in_byte == 8'h3D || in_byte == 8'h21 || in_byte == 8'h3C ||
						in_byte == 8'h3E || in_byte == 8'h7C || in_byte == 8'h26) begin
					n_mode = M_OP; n_pend = in_byte;
				end else begin
					t[n] = '{K_ERROR, pos_q, 16'd1, line_q, E_CHAR, 1'b0}; n = n + 2'd1;
					n_err = 1'b1;
				end
			end
		end
		if (n != 2'd0) t[n - 2'd1].last = 1'b1;
		if (latched && !in_end) n = '0;
	end

	assign push_n   = take ? n : 2'd0;
	assign push_tok = t;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; begin_q <= '0; len_q <= '0; line_q <= 24'd1;
			pos_q <= '0; pend_q <= '0; err_q <= 1'b0;
		end else if (take) begin
			mode_q <= n_mode; begin_q <= n_begin; len_q <= n_len;
			pend_q <= n_pend; err_q <= n_err;
			if (in_end) begin
				line_q <= 24'd1; pos_q <= '0;
			end else begin
				pos_q <= pos_q + 32'd1;
				if (in_byte == 8'h0A && line_q < LINE_MAX) line_q <= line_q + 24'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && wb_we) wbuf_q[wb_a] <= in_byte;
	end

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n) line_q != 24'd0)
		else $error("line count reached zero");
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		take && in_end |=> pos_q == 32'd0 && !err_q && mode_q == M_IDLE)
		else $error("end of input did not reset state");
	a_push_fits: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room) else $error("push without room");
endmodule

// ===== sv/slt_queue.sv =====
// ----------------------------------------------------------------------------
// slt_queue: token queue
// takes up to three tokens a cycle while it has room, hands out one while the sink is ready; drives the output stream
// ----------------------------------------------------------------------------
module slt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [1:0]    push_n,
	input  slt_pkg::tok_t push_tok [3],
	output logic          room,
	output logic          out_valid,
	output slt_pkg::tok_t out_tok,
	input  logic          out_ready
);
	import slt_pkg::*;

	localparam int DEPTH = 8;
	tok_t        mem_q [DEPTH];
	logic [2:0]  rd_q, wr_q;
	logic [3:0]  cnt_q;

	wire pop = out_valid && out_ready;
	assign out_valid = cnt_q != 4'd0;
	assign out_tok   = mem_q[rd_q];
	// three free entries guarantee any word fits
	assign room = cnt_q <= 4'(DEPTH - 3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + 3'(push_n);
			rd_q  <= rd_q + 3'(pop);
			cnt_q <= cnt_q + 4'(push_n) - 4'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++)
			if (2'(i) < push_n) mem_q[wr_q + 3'(i)] <= push_tok[i];
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(DEPTH)) else $error("queue overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> room) else $error("push without room");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && push_n == 2'd0 |=> cnt_q == $past(cnt_q) - 4'd1) else $error("count slip");
endmodule

// ===== sv/script_lexer_tokenizer.sv =====
// ----------------------------------------------------------------------------
// script_lexer_tokenizer: streaming lexer for a small scripting language
// bytes in, tokens out through a short queue
// ----------------------------------------------------------------------------
// channel  dir  tdata                          tuser
// s_axis   in   text_byte[7:0]                 kind
// m_axis   out  token_kind..error_code [79:0]  -         tlast last_of_run
// one byte or end mark accepted per cycle while the queue holds three free words
// each item yields zero to three tokens; the queue drains one token per cycle while the sink is ready
// a run of multi-token items is limited by the single output port
// reset clears scanner state and empties the queue, no clearing pass
// output stalls only hold back input once six tokens are waiting
module script_lexer_tokenizer #(
	parameter int KEYWORD_MAX = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // text_byte
	input  logic        s_axis_tuser,   // kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // token_kind, token_start, token_length,
	                                    // line_number, error_code
	output logic        m_axis_tlast    // last_of_run
);
	import slt_pkg::*;

	logic [1:0] push_n;
	tok_t       push_tok [3];
	tok_t       out_tok;
	logic       room;

	slt_front #(.KEYWORD_MAX(KEYWORD_MAX)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_end(s_axis_tuser), .in_byte(s_axis_tdata),
		.in_ready(s_axis_tready), .push_n, .push_tok, .room
	);

	slt_queue u_queue (
		.clk, .arst_n, .push_n, .push_tok, .room,
		.out_valid(m_axis_tvalid), .out_tok, .out_ready(m_axis_tready)
	);

	assign m_axis_tdata = {out_tok.err, out_tok.line, out_tok.len, out_tok.start, out_tok.kind};
	assign m_axis_tlast = out_tok.last;
endmodule

// ===== tb/script_lexer_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// script_lexer_tokenizer_tb: self-checking bench for the script lexer
// drives text bytes and end marks, predicts every token and compares each
// output word against the oldest predicted token
// ----------------------------------------------------------------------------
module script_lexer_tokenizer_tb;
	import slt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WORD_MAX       = 8;
	localparam int RANDOM_ITEMS   = 40;

	localparam logic [5:0] T_OP0    = 6'd4;
	localparam logic [5:0] T_ASSIGN = 6'd18;
	localparam logic [5:0] T_BANG   = 6'd19;
	localparam logic [5:0] T_LT     = 6'd20;
	localparam logic [5:0] T_GT     = 6'd21;
	localparam logic [5:0] T_EQEQ   = 6'd22;
	localparam logic [5:0] T_NE     = 6'd23;
	localparam logic [5:0] T_LE     = 6'd24;
	localparam logic [5:0] T_GE     = 6'd25;
	localparam logic [5:0] T_OROR   = 6'd26;
	localparam logic [5:0] T_ANDAND = 6'd27;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_EOF  = 1'b1;

	localparam string SINGLE_OPS = "(){}[],.;-+/*%";
	localparam string PAIR_OPS   = "=!<>|&";

	string keywords [16] = '{"true", "false", "null", "if", "else", "var", "for", "while",
		"return", "function", "class", "super", "this", "new", "program", "print"};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // text_byte
	logic        s_axis_tuser;   // kind
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // token_kind, token_start, token_length,
	                             // line_number, error_code
	logic        m_axis_tlast;   // last_of_run

	script_lexer_tokenizer i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// lexer shadow state
	mode_t       scan;
	logic [31:0] tok_begin;
	logic [15:0] tok_len;
	logic [23:0] line_no;
	logic [31:0] byte_pos;
	logic [7:0]  word_buf [WORD_MAX];
	logic [7:0]  pend_op;
	bit          err_sticky;
	tok_t        run_toks [$];
	tok_t        token_q [$];

	int src_idle;
	int snk_idle;
	int hold_left;
	int items_sent;
	int mismatches;
	int quiet_cycles;

	function automatic bit alpha_ch(logic [7:0] b);
		return b == "_" || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit digit_ch(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [5:0] single_code(logic [7:0] b);
		for (int i = 0; i < SINGLE_OPS.len(); i++)
			if (SINGLE_OPS[i] == b) return T_OP0 + 6'(i);
		return K_END;
	endfunction

	function automatic logic [5:0] op_code(logic [7:0] f, bit pair);
		case (f)
			"=": return pair ? T_EQEQ : T_ASSIGN;
			"!": return pair ? T_NE : T_BANG;
			"<": return pair ? T_LE : T_LT;
			">": return pair ? T_GE : T_GT;
			"|": return T_OROR;
			default: return T_ANDAND;
		endcase
	endfunction

	task automatic clear_lexer();
		scan = M_IDLE;
		tok_begin = '0;
		tok_len = '0;
		line_no = 24'd1;
		byte_pos = '0;
		foreach (word_buf[i]) word_buf[i] = '0;
		pend_op = '0;
		err_sticky = 1'b0;
	endtask

	task automatic put_token(logic [5:0] k, logic [31:0] st, logic [15:0] l, logic [1:0] e);
		tok_t t;
		if (run_toks.size() < 3) begin
			t.kind = k;
			t.start = st;
			t.len = l;
			t.line = line_no;
			t.err = e;
			t.last = 1'b0;
			run_toks.push_back(t);
		end
	endtask

	task automatic grow();
		if (tok_len != LEN_MAX) tok_len++;
	endtask

	task automatic put_word();
		logic [5:0] k;
		bit same;
		k = K_IDENT;
		for (int i = 0; i < 16; i++) begin
			if (k == K_IDENT && tok_len == keywords[i].len() && tok_len <= WORD_MAX) begin
				same = 1'b1;
				for (int j = 0; j < keywords[i].len(); j++)
					if (word_buf[j] != keywords[i][j]) same = 1'b0;
				if (same) k = K_KEYWORD0 + 6'(i);
			end
		end
		put_token(k, tok_begin, tok_len, E_NONE);
	endtask

	task automatic raise_err(logic [31:0] st, logic [15:0] l, logic [1:0] e);
		put_token(K_ERROR, st, l, e);
		err_sticky = 1'b1;
		scan = M_IDLE;
	endtask

	task automatic start_token(logic [7:0] b, logic [31:0] p);
		scan = M_IDLE;
		tok_begin = p;
		tok_len = '0;
		if (b == " " || b == 8'h09 || b == 8'h0D || b == 8'h0A) return;
		if (alpha_ch(b)) begin
			scan = M_IDENT;
			tok_len = 16'd1;
			word_buf[0] = b;
		end else if (digit_ch(b)) begin
			scan = M_INT;
			tok_len = 16'd1;
		end else if (b == "\"") begin
			scan = M_STRING;
			tok_begin = p + 1;
		end else if (single_code(b) != K_END) begin
			put_token(single_code(b), p, 16'd1, E_NONE);
		end else if (b == "=" || b == "!" || b == "<" || b == ">" || b == "|" || b == "&") begin
			scan = M_OP;
			pend_op = b;
		end else begin
			raise_err(p, 16'd1, E_CHAR);
		end
	endtask

	task automatic scan_byte(logic [7:0] b, logic [31:0] p);
		if (err_sticky) return;
		case (scan)
			M_IDENT: begin
				if (alpha_ch(b) || digit_ch(b)) begin
					if (tok_len < WORD_MAX) word_buf[tok_len] = b;
					grow();
					return;
				end
				put_word();
			end
			M_INT: begin
				if (digit_ch(b)) begin
					grow();
					return;
				end
				if (b == ".") begin
					scan = M_DOT;
					return;
				end
				put_token(K_NUMBER, tok_begin, tok_len, E_NONE);
			end
			M_DOT: begin
				if (digit_ch(b)) begin
					grow();
					grow();
					scan = M_FRAC;
					return;
				end
				put_token(K_NUMBER, tok_begin, tok_len, E_NONE);
				put_token(K_DOT, p - 1, 16'd1, E_NONE);
			end
			M_FRAC: begin
				if (digit_ch(b)) begin
					grow();
					return;
				end
				put_token(K_NUMBER, tok_begin, tok_len, E_NONE);
			end
			M_STRING: begin
				if (b == "\"") begin
					put_token(K_STRING, tok_begin, tok_len, E_NONE);
					scan = M_IDLE;
				end else begin
					grow();
				end
				return;
			end
			M_OP: begin
				if (pend_op == "|" || pend_op == "&") begin
					if (b == pend_op) begin
						put_token(op_code(pend_op, 1'b1), p - 1, 16'd2, E_NONE);
						scan = M_IDLE;
					end else begin
						raise_err(p - 1, 16'd1, E_LONE);
					end
					return;
				end
				if (b == "=") begin
					put_token(op_code(pend_op, 1'b1), p - 1, 16'd2, E_NONE);
					scan = M_IDLE;
					return;
				end
				put_token(op_code(pend_op, 1'b0), p - 1, 16'd1, E_NONE);
			end
			default: ;
		endcase
		start_token(b, p);
	endtask

	task automatic end_text();
		if (!err_sticky) begin
			case (scan)
				M_IDENT: put_word();
				M_INT, M_FRAC: put_token(K_NUMBER, tok_begin, tok_len, E_NONE);
				M_DOT: begin
					put_token(K_NUMBER, tok_begin, tok_len, E_NONE);
					put_token(K_DOT, byte_pos - 1, 16'd1, E_NONE);
				end
				M_STRING: put_token(K_ERROR, tok_begin, tok_len, E_STRING);
				M_OP: begin
					if (pend_op == "|" || pend_op == "&")
						put_token(K_ERROR, byte_pos - 1, 16'd1, E_LONE);
					else
						put_token(op_code(pend_op, 1'b0), byte_pos - 1, 16'd1, E_NONE);
				end
				default: ;
			endcase
		end
		put_token(K_END, byte_pos, 16'd0, E_NONE);
	endtask

	task automatic predict_tokens(logic k, logic [7:0] b);
		run_toks.delete();
		if (k == KIND_EOF) begin
			end_text();
			clear_lexer();
		end else begin
			scan_byte(b, byte_pos);
			if (b == 8'h0A && line_no != LINE_MAX) line_no++;
			byte_pos++;
		end
		if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last = 1'b1;
		foreach (run_toks[i]) token_q.push_back(run_toks[i]);
	endtask

	always @(posedge clk)
		if (s_axis_tvalid && s_axis_tready) predict_tokens(s_axis_tuser, s_axis_tdata);

	always @(posedge clk) begin
		tok_t want;
		tok_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[5:0], m_axis_tdata[37:6], m_axis_tdata[53:38],
				m_axis_tdata[77:54], m_axis_tdata[79:78], m_axis_tlast};
			if (token_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected token word kind %0d start %0d", got.kind, got.start);
			end else begin
				want = token_q.pop_front();
				if (got.kind != want.kind || got.start != want.start || got.len != want.len ||
					got.line != want.line || got.err != want.err || got.last != want.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"token mismatch exp k%0d s%0d l%0d ln%0d e%0d t%0d",
							" got k%0d s%0d l%0d ln%0d e%0d t%0d"},
							want.kind, want.start, want.len, want.line, want.err, want.last,
							got.kind, got.start, got.len, got.line, got.err, got.last);
				end
			end
		end
	end

	// sink side, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready = 1'b0;
		end else begin
			m_axis_tready = $urandom_range(99) >= snk_idle;
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic send_item(logic k, logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < src_idle) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = k;
		s_axis_tdata = b;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_item(KIND_BYTE, s[i]);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (token_q.size() != 0) @(posedge clk);
	endtask

	task automatic send_random_token();
		int n;
		case ($urandom_range(11))
			0, 1: send_text(keywords[$urandom_range(15)]);
			2: begin
				n = $urandom_range(11, 1);
				send_item(KIND_BYTE, "a" + 8'($urandom_range(25)));
				for (int i = 1; i < n; i++)
					send_item(KIND_BYTE, $urandom_range(1) ? "0" + 8'($urandom_range(9))
						: "A" + 8'($urandom_range(25)));
			end
			3: repeat ($urandom_range(4, 1)) send_item(KIND_BYTE, "0" + 8'($urandom_range(9)));
			4: begin
				repeat ($urandom_range(3, 1)) send_item(KIND_BYTE, "0" + 8'($urandom_range(9)));
				send_item(KIND_BYTE, ".");
				repeat ($urandom_range(3)) send_item(KIND_BYTE, "0" + 8'($urandom_range(9)));
			end
			5: begin
				send_item(KIND_BYTE, "\"");
				repeat ($urandom_range(5))
					send_item(KIND_BYTE, $urandom_range(7) == 0 ? 8'h0A
						: 8'($urandom_range(126, 32)));
				if ($urandom_range(5) != 0) send_item(KIND_BYTE, "\"");
			end
			6: send_item(KIND_BYTE, SINGLE_OPS[$urandom_range(SINGLE_OPS.len() - 1)]);
			7, 8: begin
				n = $urandom_range(PAIR_OPS.len() - 1);
				send_item(KIND_BYTE, PAIR_OPS[n]);
				if (n >= 4) send_item(KIND_BYTE, PAIR_OPS[n]);
				else if ($urandom_range(1)) send_item(KIND_BYTE, "=");
			end
			9: send_item(KIND_BYTE, 8'($urandom_range(255)));
			10: send_item(KIND_EOF, 8'($urandom_range(255)));
			default: send_item(KIND_BYTE, $urandom_range(3) == 0 ? 8'h0A : " ");
		endcase
		case ($urandom_range(5))
			0: send_item(KIND_BYTE, " ");
			1: send_item(KIND_BYTE, 8'h0A);
			2: send_item(KIND_BYTE, $urandom_range(1) ? 8'h09 : 8'h0D);
			default: ;
		endcase
	endtask

	task automatic test_directed();
		src_idle = 0;
		snk_idle = 0;
		send_text("if whilex abcdefghij\n");
		send_text("3.14 7.x ");
		send_text("== != <= >= || && a=b\"s\nt\" ");
		send_item(KIND_EOF, 8'h00);
		send_text("|x");
		send_item(KIND_EOF, 8'hFF);
		send_text("& ");
		send_item(KIND_EOF, 8'h00);
		send_text("x @ y\n");
		send_item(KIND_EOF, 8'h00);
		send_item(KIND_BYTE, 8'hFF);
		send_item(KIND_EOF, 8'h00);
		send_text("\"ab\nc");
		send_item(KIND_EOF, 8'h00);
		send_text("42.");
		send_item(KIND_EOF, 8'h00);
		send_text("abc|");
		send_item(KIND_EOF, 8'h00);
		send_text("<");
		send_item(KIND_EOF, 8'h00);
		wait_drained();
	endtask

	task automatic test_random_phase(int src_pct, int snk_pct, int count);
		int target;
		src_idle = src_pct;
		snk_idle = snk_pct;
		target = items_sent + count;
		while (items_sent < target) send_random_token();
		send_item(KIND_EOF, 8'($urandom_range(255)));
		wait_drained();
	endtask

	task automatic test_backpressure();
		src_idle = 0;
		snk_idle = 0;
		@(negedge clk);
		hold_left = 300;
		// the queue fills and the input stalls while the sink holds off
		repeat (3) send_text("3.x (a)");
		send_item(KIND_EOF, 8'h00);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = KIND_BYTE;
		m_axis_tready = 1'b0;
		src_idle = 0;
		snk_idle = 0;
		hold_left = 0;
		items_sent = 0;
		mismatches = 0;
		quiet_cycles = 0;
		clear_lexer();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_phase(0, 0, RANDOM_ITEMS / 4);
		test_random_phase(79, 0, RANDOM_ITEMS / 4);
		test_random_phase(0, 79, RANDOM_ITEMS / 4);
		test_random_phase(8, 8, RANDOM_ITEMS / 4);
		test_backpressure();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && token_q.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
